[sv/bms_pkg.sv]
// ----------------------------------------------------------------------------
// bms_pkg
// Shared constants and small lookup functions for the gaussian sampler.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int UNIFORM_BITS_DEF = 32;

    // fixed point constants
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
    localparam logic [28:0] TWO_LN2_Q28  = 29'd372130559;

    localparam int LOG_STEPS    = 28;
    localparam int SERIES_TERMS = 5;

    // configuration register indexes
    localparam logic CFG_MEAN = 1'b0;
    localparam logic CFG_STD  = 1'b1;

    // horner divisors, innermost term first
    function automatic int cos_div(input int step);
        int d;
        d = 2;
        case (step)
            0:       d = 90;
            1:       d = 56;
            2:       d = 30;
            3:       d = 12;
            default: d = 2;
        endcase
        return d;
    endfunction

    function automatic int sin_div(input int step);
        int d;
        d = 6;
        case (step)
            0:       d = 110;
            1:       d = 72;
            2:       d = 42;
            3:       d = 20;
            default: d = 6;
        endcase
        return d;
    endfunction

endpackage

[sv/bms_log_cell.sv]
// ----------------------------------------------------------------------------
// bms_log_cell
// One squaring step of the binary logarithm: squares the mantissa and
// shifts one fraction bit into the running result.
// ----------------------------------------------------------------------------
module bms_log_cell #(
    parameter int SIDE_W = 37
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [30:0]       i_m,
    input  logic [27:0]       i_frac,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [30:0]       o_m,
    output logic [27:0]       o_frac,
    output logic [SIDE_W-1:0] o_side
);
    import bms_pkg::*;

    logic [61:0] w_prod;
    logic [31:0] w_sq;
    logic        w_ovf;
    logic [30:0] n_m;
    logic [27:0] n_frac;

    logic              r_valid;
    logic [30:0]       r_m;
    logic [27:0]       r_frac;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        w_prod = 62'(i_m) * 62'(i_m);
        w_sq   = w_prod[61:30];
        // mantissa reached 2.0
        w_ovf  = w_sq[31];
        n_m    = w_ovf ? w_sq[31:1] : w_sq[30:0];
        n_frac = {i_frac[26:0], w_ovf};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_frac <= n_frac;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_frac  = r_frac;
    assign o_side  = r_side;

endmodule

[sv/bms_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// bms_sqrt_cell
// One digit of a restoring integer square root: takes the next two radicand
// bits and decides one root bit.
// ----------------------------------------------------------------------------
module bms_sqrt_cell #(
    parameter int SW     = 32,
    parameter int VW     = 64,
    parameter int SIDE_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [VW-1:0]     i_v,
    input  logic [SW+1:0]     i_rem,
    input  logic [SW-1:0]     i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [VW-1:0]     o_v,
    output logic [SW+1:0]     o_rem,
    output logic [SW-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);
    import bms_pkg::*;

    logic [SW+3:0] w_cur;
    logic [SW+3:0] w_trial;
    logic [SW+3:0] w_diff;
    logic          w_ge;

    logic              r_valid;
    logic [VW-1:0]     r_v;
    logic [SW+1:0]     r_rem;
    logic [SW-1:0]     r_root;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        w_cur   = {i_rem, i_v[VW-1:VW-2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_ge    = (w_cur >= w_trial);
        w_diff  = w_ge ? (w_cur - w_trial) : w_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= i_v << 2;
            r_rem  <= w_diff[SW+1:0];
            r_root <= {i_root[SW-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

[sv/bms_horner_cell.sv]
// ----------------------------------------------------------------------------
// bms_horner_cell
// One term of the cosine or sine series: t = 1 - round(x2 * t / d), with the
// division done by a reciprocal multiply. Two register stages.
// ----------------------------------------------------------------------------
module bms_horner_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_use_sin,
    input  logic [29:0]       i_x2,
    input  logic [30:0]       i_t,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic              o_use_sin,
    output logic [29:0]       o_x2,
    output logic [30:0]       o_t,
    output logic [SIDE_W-1:0] o_side
);
    import bms_pkg::*;

    localparam int D_COS = cos_div(STEP);
    localparam int D_SIN = sin_div(STEP);
    localparam int L_COS = $clog2(D_COS);
    localparam int L_SIN = $clog2(D_SIN);
    localparam int S_COS = 31 + L_COS;
    localparam int S_SIN = 31 + L_SIN;
    localparam logic [31:0] M_COS = 32'(((64'd1 << S_COS) + 64'(D_COS) - 64'd1) / 64'(D_COS));
    localparam logic [31:0] M_SIN = 32'(((64'd1 << S_SIN) + 64'(D_SIN) - 64'd1) / 64'(D_SIN));
    localparam logic [30:0] H_COS = 31'(D_COS / 2);
    localparam logic [30:0] H_SIN = 31'(D_SIN / 2);

    logic [60:0] w_mul;
    logic [30:0] w_n;
    logic [62:0] w_prod;
    logic [30:0] w_q;

    // stage a
    logic              r_a_valid;
    logic              r_a_use_sin;
    logic [29:0]       r_a_x2;
    logic [30:0]       r_a_y;
    logic [SIDE_W-1:0] r_a_side;

    // stage b
    logic              r_b_valid;
    logic              r_b_use_sin;
    logic [29:0]       r_b_x2;
    logic [30:0]       r_b_t;
    logic [SIDE_W-1:0] r_b_side;

    always_comb begin
        w_mul  = 61'(i_x2) * 61'(i_t) + 61'(Q30_ONE >> 1);
        w_n    = r_a_y + (r_a_use_sin ? H_SIN : H_COS);
        w_prod = 63'(w_n) * 63'(r_a_use_sin ? M_SIN : M_COS);
        w_q    = r_a_use_sin ? 31'(w_prod >> S_SIN) : 31'(w_prod >> S_COS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_use_sin <= i_use_sin;
            r_a_x2      <= i_x2;
            r_a_y       <= w_mul[60:30];
            r_a_side    <= i_side;
            r_b_use_sin <= r_a_use_sin;
            r_b_x2      <= r_a_x2;
            r_b_t       <= Q30_ONE - w_q;
            r_b_side    <= r_a_side;
        end
    end

    assign o_valid   = r_b_valid;
    assign o_use_sin = r_b_use_sin;
    assign o_x2      = r_b_x2;
    assign o_t       = r_b_t;
    assign o_side    = r_b_side;

endmodule

[sv/box_muller_gaussian_sampler.sv]
// ----------------------------------------------------------------------------
// box_muller_gaussian_sampler
// Box-Muller normal sample generator, cosine branch, in fixed point.
// ----------------------------------------------------------------------------
// Takes one request of two uniform fractions per clock and gives one signed
// Q16.16 sample mean + std * sqrt(-2 ln u1) * cos(2 pi u2), saturated, per
// clock while neither side stalls. The datapath is a row of cells: 28
// squaring cells for the logarithm, one cell per root bit for the square
// root (32 at the default width) and five two-stage series cells for the
// cosine. An output register and a one-entry skid stage sit behind the last
// cell; the input stalls only while the skid holds a result. Configuration
// is to be written only while the block is empty; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module box_muller_gaussian_sampler #(
    parameter int UNIFORM_BITS = bms_pkg::UNIFORM_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_addr,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_uniform_radius,
    input  logic [31:0]        i_uniform_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_normal_sample
);
    import bms_pkg::*;

    localparam int EW    = 5;
    localparam int LW    = $clog2(UNIFORM_BITS + 1) + 28;
    localparam int RW    = LW + 1;
    localparam int SW    = (RW + 28 + 1) / 2;
    localparam int VW    = 2 * SW;
    localparam int QW    = SW - 4;
    localparam int SUMW  = ((QW > 32) ? QW : 32) + 2;
    localparam int A_SHR = (UNIFORM_BITS >= 32) ? (UNIFORM_BITS - 32) : 0;
    localparam int A_SHL = (UNIFORM_BITS < 32) ? (32 - UNIFORM_BITS) : 0;
    localparam int LSIDE = EW + 32;
    localparam int HSIDE = 30 + SW + 1;
    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(-64'sh0000_0000_8000_0000);

    logic w_en;

    // configuration
    logic signed [31:0] r_mean;
    logic [23:0]        r_std;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
            r_std  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_MEAN: r_mean <= i_cfg_wr_data;
                CFG_STD:  r_std  <= i_cfg_wr_data[23:0];
                default: ;
            endcase
        end
    end

    // input normalize
    logic [31:0]   w_k_raw;
    logic [31:0]   w_k;
    logic [31:0]   w_angle;
    logic [EW-1:0] w_e;
    logic [31:0]   w_kn;

    always_comb begin
        w_k_raw = (i_uniform_radius << A_SHL) >> A_SHL;
        w_k     = (w_k_raw == 32'd0) ? 32'd1 : w_k_raw;
        w_angle = (i_uniform_angle >> A_SHR) << A_SHL;
        w_e     = '0;
        for (int i = 0; i < 32; i++) begin
            if (w_k[i]) begin
                w_e = EW'(i);
            end
        end
        w_kn = w_k << (5'd31 - w_e);
    end

    logic          r_s0_valid;
    logic [30:0]   r_s0_m;
    logic [EW-1:0] r_s0_e;
    logic [31:0]   r_s0_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_m     <= w_kn[31:1];
            r_s0_e     <= w_e;
            r_s0_angle <= w_angle;
        end
    end

    // logarithm chain
    logic             w_lg_valid [0:LOG_STEPS];
    logic [30:0]      w_lg_m     [0:LOG_STEPS];
    logic [27:0]      w_lg_frac  [0:LOG_STEPS];
    logic [LSIDE-1:0] w_lg_side  [0:LOG_STEPS];

    assign w_lg_valid[0] = r_s0_valid;
    assign w_lg_m[0]     = r_s0_m;
    assign w_lg_frac[0]  = '0;
    assign w_lg_side[0]  = {r_s0_e, r_s0_angle};

    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        bms_log_cell #(
            .SIDE_W (LSIDE)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_lg_valid[g]),
            .i_m     (w_lg_m[g]),
            .i_frac  (w_lg_frac[g]),
            .i_side  (w_lg_side[g]),
            .o_valid (w_lg_valid[g+1]),
            .o_m     (w_lg_m[g+1]),
            .o_frac  (w_lg_frac[g+1]),
            .o_side  (w_lg_side[g+1])
        );
    end

    // -2 ln u1 = -log2(u1) * 2 ln 2
    logic [EW-1:0]  w_lg_e;
    logic [LW-1:0]  w_l;
    logic [LW+28:0] w_rprod;

    always_comb begin
        w_lg_e  = w_lg_side[LOG_STEPS][LSIDE-1:32];
        w_l     = ((LW'(UNIFORM_BITS) - LW'(w_lg_e)) << 28) - LW'(w_lg_frac[LOG_STEPS]);
        w_rprod = (LW+29)'(w_l) * (LW+29)'(TWO_LN2_Q28) + ((LW+29)'(1) << 27);
    end

    logic          r_r_valid;
    logic [RW-1:0] r_r;
    logic [31:0]   r_r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (w_en) begin
            r_r_valid <= w_lg_valid[LOG_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r       <= w_rprod[RW+27:28];
            r_r_angle <= w_lg_side[LOG_STEPS][31:0];
        end
    end

    // square root chain
    logic          w_sq_valid [0:SW];
    logic [VW-1:0] w_sq_v     [0:SW];
    logic [SW+1:0] w_sq_rem   [0:SW];
    logic [SW-1:0] w_sq_root  [0:SW];
    logic [31:0]   w_sq_side  [0:SW];

    assign w_sq_valid[0] = r_r_valid;
    assign w_sq_v[0]     = VW'({r_r, 28'd0});
    assign w_sq_rem[0]   = '0;
    assign w_sq_root[0]  = '0;
    assign w_sq_side[0]  = r_r_angle;

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        bms_sqrt_cell #(
            .SW     (SW),
            .VW     (VW),
            .SIDE_W (32)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_valid[g]),
            .i_v     (w_sq_v[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_valid[g+1]),
            .o_v     (w_sq_v[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    // angle fold and scale to radians
    logic [1:0]  w_quad;
    logic [29:0] w_r;
    logic        w_folded;
    logic [29:0] w_rf;
    logic [60:0] w_xprod;

    always_comb begin
        w_quad   = w_sq_side[SW][31:30];
        w_r      = w_sq_side[SW][29:0];
        w_folded = (w_r > 30'h2000_0000);
        w_rf     = w_folded ? (30'h0 - w_r) : w_r;
        w_xprod  = 61'(w_rf) * 61'(HALF_PI_Q30) + 61'(Q30_ONE >> 1);
    end

    logic          r_t0_valid;
    logic [29:0]   r_t0_x;
    logic          r_t0_use_sin;
    logic          r_t0_neg;
    logic [SW-1:0] r_t0_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_valid <= 1'b0;
        end else if (w_en) begin
            r_t0_valid <= w_sq_valid[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0_x       <= w_xprod[59:30];
            r_t0_use_sin <= w_quad[0] ^ w_folded;
            r_t0_neg     <= w_quad[0] ^ w_quad[1];
            r_t0_s       <= w_sq_root[SW];
        end
    end

    // x squared
    logic [59:0] w_x2prod;

    assign w_x2prod = 60'(r_t0_x) * 60'(r_t0_x) + 60'(Q30_ONE >> 1);

    logic          r_t1_valid;
    logic [29:0]   r_t1_x;
    logic [29:0]   r_t1_x2;
    logic          r_t1_use_sin;
    logic          r_t1_neg;
    logic [SW-1:0] r_t1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
        end else if (w_en) begin
            r_t1_valid <= r_t0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_x       <= r_t0_x;
            r_t1_x2      <= w_x2prod[59:30];
            r_t1_use_sin <= r_t0_use_sin;
            r_t1_neg     <= r_t0_neg;
            r_t1_s       <= r_t0_s;
        end
    end

    // series chain
    logic             w_hn_valid   [0:SERIES_TERMS];
    logic             w_hn_use_sin [0:SERIES_TERMS];
    logic [29:0]      w_hn_x2      [0:SERIES_TERMS];
    logic [30:0]      w_hn_t       [0:SERIES_TERMS];
    logic [HSIDE-1:0] w_hn_side    [0:SERIES_TERMS];

    assign w_hn_valid[0]   = r_t1_valid;
    assign w_hn_use_sin[0] = r_t1_use_sin;
    assign w_hn_x2[0]      = r_t1_x2;
    assign w_hn_t[0]       = Q30_ONE;
    assign w_hn_side[0]    = {r_t1_x, r_t1_s, r_t1_neg};

    for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_series
        bms_horner_cell #(
            .STEP   (g),
            .SIDE_W (HSIDE)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_valid   (w_hn_valid[g]),
            .i_use_sin (w_hn_use_sin[g]),
            .i_x2      (w_hn_x2[g]),
            .i_t       (w_hn_t[g]),
            .i_side    (w_hn_side[g]),
            .o_valid   (w_hn_valid[g+1]),
            .o_use_sin (w_hn_use_sin[g+1]),
            .o_x2      (w_hn_x2[g+1]),
            .o_t       (w_hn_t[g+1]),
            .o_side    (w_hn_side[g+1])
        );
    end

    // sine branch multiplies by x once more
    logic [29:0]   w_hx;
    logic [SW-1:0] w_hs;
    logic          w_hneg;
    logic [60:0]   w_cprod;

    always_comb begin
        w_hx    = w_hn_side[SERIES_TERMS][HSIDE-1:SW+1];
        w_hs    = w_hn_side[SERIES_TERMS][SW:1];
        w_hneg  = w_hn_side[SERIES_TERMS][0];
        w_cprod = 61'(w_hx) * 61'(w_hn_t[SERIES_TERMS]) + 61'(Q30_ONE >> 1);
    end

    logic          r_c_valid;
    logic [30:0]   r_c;
    logic [SW-1:0] r_c_s;
    logic          r_c_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= w_hn_valid[SERIES_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c     <= w_hn_use_sin[SERIES_TERMS] ? w_cprod[60:30] : w_hn_t[SERIES_TERMS];
            r_c_s   <= w_hs;
            r_c_neg <= w_hneg;
        end
    end

    // radius times cosine, then times deviation
    logic [SW+30:0] w_pprod;
    logic [SW+23:0] w_qprod;

    logic          r_p_valid;
    logic [SW-1:0] r_p;
    logic          r_p_neg;
    logic          r_q_valid;
    logic [QW-1:0] r_q;
    logic          r_q_neg;

    always_comb begin
        w_pprod = (SW+31)'(r_c_s) * (SW+31)'(r_c) + (SW+31)'(Q30_ONE >> 1);
        w_qprod = (SW+24)'(r_p) * (SW+24)'(r_std) + ((SW+24)'(1) << 27);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= r_c_valid;
            r_q_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p     <= w_pprod[SW+29:30];
            r_p_neg <= r_c_neg;
            r_q     <= w_qprod[SW+23:28];
            r_q_neg <= r_p_neg;
        end
    end

    // add mean and saturate
    logic signed [SUMW-1:0] w_mean_x;
    logic signed [SUMW-1:0] w_q_x;
    logic signed [SUMW-1:0] w_sum;
    logic signed [31:0]     w_result;

    always_comb begin
        w_mean_x = SUMW'(r_mean);
        w_q_x    = signed'(SUMW'(r_q));
        w_sum    = r_q_neg ? (w_mean_x - w_q_x) : (w_mean_x + w_q_x);
        if (w_sum > SAT_HI) begin
            w_result = 32'sh7FFF_FFFF;
        end else if (w_sum < SAT_LO) begin
            w_result = 32'sh8000_0000;
        end else begin
            w_result = w_sum[31:0];
        end
    end

    // output register and skid
    logic               r_out_valid;
    logic signed [31:0] r_out;
    logic               r_skid_valid;
    logic signed [31:0] r_skid;
    logic               w_take;
    logic               w_tail;

    assign w_en   = !r_skid_valid;
    assign w_take = !r_out_valid || !i_out_stall;
    assign w_tail = r_q_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid  <= r_skid_valid || w_tail;
            r_skid_valid <= 1'b0;
        end else if (w_tail) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end else if (w_tail) begin
            r_skid <= w_result;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_normal_sample = r_out;

endmodule

[verif/box_muller_gaussian_sampler_checker.sv]
// ----------------------------------------------------------------------------
// box_muller_gaussian_sampler_checker
// Watches both channels of the gaussian sampler, computes the expected sample
// for every accepted request in fixed point and compares it with each result.
// ----------------------------------------------------------------------------
module box_muller_gaussian_sampler_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_addr,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [31:0]        i_uniform_radius,
    input  logic [31:0]        i_uniform_angle,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_normal_sample,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_sample_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import bms_pkg::*;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    logic signed [31:0] mean_reg;
    logic [23:0]        std_reg;
    logic signed [31:0] sample_queue[$];

    function automatic logic [63:0] mul_round_q30(logic [63:0] a, logic [63:0] b);
        return (a * b + (ONE_Q30 >> 1)) >> 30;
    endfunction

    // -log2(k / 2^32) in Q28
    function automatic logic [63:0] neg_log2(logic [63:0] k);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb = 0;
        frac = 0;
        for (int i = 0; i < 64; i++) if (k[i]) msb = i;
        if (msb <= 30) m = k << (30 - msb);
        else m = k >> (msb - 30);
        for (int i = 1; i <= 28; i++) begin
            m = (m * m) >> 30;
            if (m >= (ONE_Q30 << 1)) begin
                m = m >> 1;
                frac[28-i] = 1'b1;
            end
        end
        return (64'(32 - msb) << 28) - frac;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] horner(logic [63:0] x2, bit sine);
        logic [63:0] t;
        logic [63:0] d;
        t = ONE_Q30;
        for (int i = 0; i < 5; i++) begin
            case (i)
                0: d = sine ? 110 : 90;
                1: d = sine ? 72 : 56;
                2: d = sine ? 42 : 30;
                3: d = sine ? 20 : 12;
                default: d = sine ? 6 : 2;
            endcase
            t = ONE_Q30 - (mul_round_q30(x2, t) + d / 2) / d;
        end
        return t;
    endfunction

    function automatic logic signed [31:0] predict_sample(logic [31:0] radius,
                                                         logic [31:0] angle);
        logic [63:0]        k, lg, r2, root, rem, x, x2, cmag, p, q;
        logic [1:0]         quad;
        bit                 folded, sine, neg;
        logic signed [63:0] sum;
        k = (radius == 0) ? 64'd1 : 64'(radius);
        lg = neg_log2(k);
        r2 = (lg * 64'd372130559 + (64'd1 << 27)) >> 28;
        root = int_sqrt(r2 << 28);
        quad = angle[31:30];
        rem = 64'(angle[29:0]);
        folded = 0;
        if (rem > (ONE_Q30 >> 1)) begin
            rem = ONE_Q30 - rem;
            folded = 1;
        end
        x = (rem * 64'd1686629713 + (ONE_Q30 >> 1)) >> 30;
        x2 = mul_round_q30(x, x);
        sine = quad[0] ^ folded;
        neg = (quad == 2'd1) || (quad == 2'd2);
        cmag = sine ? mul_round_q30(x, horner(x2, 1'b1)) : horner(x2, 1'b0);
        p = (root * cmag + (ONE_Q30 >> 1)) >> 30;
        q = (p * 64'(std_reg) + (64'd1 << 27)) >> 28;
        sum = neg ? 64'(mean_reg) - $signed(q) : 64'(mean_reg) + $signed(q);
        if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
        if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
        return sum[31:0];
    endfunction

    assign o_pending = sample_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mean_reg <= 0;
            std_reg <= 0;
            sample_queue.delete();
            o_fail_count <= 0;
            o_sample_count <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == CFG_MEAN) mean_reg <= i_cfg_wr_data;
                else std_reg <= i_cfg_wr_data[23:0];
            end
            if (i_out_valid && !i_out_stall) begin
                o_sample_count <= o_sample_count + 1;
                if (sample_queue.size() == 0) begin
                    $error("unexpected result normal_sample=%0d", i_normal_sample);
                    o_fail_count <= o_fail_count + 1;
                end else if (sample_queue[0] !== i_normal_sample) begin
                    $error("normal_sample mismatch: expected %0d actual %0d",
                           sample_queue[0], i_normal_sample);
                    o_fail_count <= o_fail_count + 1;
                    void'(sample_queue.pop_front());
                end else begin
                    void'(sample_queue.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall)
                sample_queue.push_back(predict_sample(i_uniform_radius, i_uniform_angle));
        end
    end
endmodule

[verif/box_muller_gaussian_sampler_tb.sv]
// ----------------------------------------------------------------------------
// box_muller_gaussian_sampler_tb
// Drives uniform pairs into the gaussian sampler over several mean and
// deviation settings, with random gaps and stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module box_muller_gaussian_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bms_pkg::*;

    localparam int DRAIN_CYCLES = 120;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               cfg_wr_en = 0;
    logic               cfg_addr = CFG_MEAN;
    logic [31:0]        cfg_wr_data = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [31:0]        uniform_radius = 0;
    logic [31:0]        uniform_angle = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [31:0] normal_sample;
    int                 fail_count;
    int                 pending;
    int                 sample_count;
    bit                 hold_off_now = 0;
    logic [31:0]        radius_list[$];
    logic [31:0]        angle_list[$];

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    box_muller_gaussian_sampler u_dut (
        .i_clk, .i_rst_n,
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_addr(cfg_addr), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_uniform_radius(uniform_radius), .i_uniform_angle(uniform_angle),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_normal_sample(normal_sample)
    );

    box_muller_gaussian_sampler_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_addr(cfg_addr), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_uniform_radius(uniform_radius), .i_uniform_angle(uniform_angle),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_normal_sample(normal_sample),
        .o_fail_count(fail_count), .o_pending(pending), .o_sample_count(sample_count)
    );

    // receiver: random stalls per result, plus one long hold-off on request
    always @(posedge i_clk) begin
        int wait_n;
        if (i_rst_n) begin
            if (hold_off_now) begin
                out_stall <= 1;
                repeat (400) @(posedge i_clk);
                hold_off_now = 0;
                out_stall <= 0;
            end else if (!out_stall && out_valid) begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (wait_n > 0) begin
                    out_stall <= 1;
                    repeat (wait_n) @(posedge i_clk);
                    out_stall <= 0;
                end
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        @(posedge i_clk);
        cfg_wr_en <= 0;
    endtask

    task automatic send_requests(int max_gap);
        int gap;
        while (radius_list.size() > 0) begin
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                in_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            in_valid <= 1;
            uniform_radius <= radius_list.pop_front();
            uniform_angle <= angle_list.pop_front();
            @(posedge i_clk);
            while (in_stall) @(posedge i_clk);
        end
        in_valid <= 0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_radius();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        logic [31:0] corner;
        case ($urandom_range(0, 4))
            0: begin
                corner = {2'($urandom_range(0, 3)), 30'h0};
                corner[29:0] = ($urandom_range(0, 1)) ? 30'h2000_0000 : 30'h0;
                return corner + $urandom_range(0, 2) - 1;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count, int max_gap);
        for (int i = 0; i < count; i++) begin
            radius_list.push_back(pick_radius());
            angle_list.push_back(pick_angle());
        end
        send_requests(max_gap);
    endtask

    initial begin
        logic [31:0] edge_radius[7];
        logic [31:0] edge_angle[8];
        edge_radius = '{32'd0, 32'd1, 32'd2, 32'h8000_0000, 32'hFFFF_FFFF,
                        32'h0000_FFFF, 32'h5555_5555};
        edge_angle = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                       32'h2000_0000, 32'h2000_0001, 32'hFFFF_FFFF, 32'hAAAA_AAAA};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset settings: zero deviation gives the mean exactly
        radius_list.push_back(32'd0);
        angle_list.push_back(32'h0);
        send_requests(0);
        drain_results();

        write_reg(CFG_MEAN, 32'h0001_0000);
        write_reg(CFG_STD, 32'h00_FFFF);
        for (int r = 0; r < 7; r++) begin
            radius_list.push_back(edge_radius[r]);
            angle_list.push_back(edge_angle[r]);
        end
        for (int a = 0; a < 8; a++) begin
            radius_list.push_back(32'd0);
            angle_list.push_back(edge_angle[a]);
        end
        send_requests(2);
        drain_results();

        // saturation at both ends with the widest deviation
        write_reg(CFG_MEAN, 32'h7FFF_FFFF);
        write_reg(CFG_STD, 32'hFF_FFFF);
        for (int a = 0; a < 4; a++) begin
            radius_list.push_back(32'd1);
            angle_list.push_back(edge_angle[a]);
        end
        send_requests(0);
        drain_results();
        write_reg(CFG_MEAN, 32'h8000_0000);
        for (int a = 0; a < 4; a++) begin
            radius_list.push_back(32'd1);
            angle_list.push_back(edge_angle[a]);
        end
        send_requests(0);
        drain_results();

        for (int phase = 0; phase < 7; phase++) begin
            write_reg(CFG_MEAN, $urandom);
            write_reg(CFG_STD, (phase == 0) ? 32'h0 : $urandom >> $urandom_range(8, 24));
            if (phase == 2) hold_off_now = 1;
            random_phase(200, (phase % 3 == 1) ? 0 : 12);
            drain_results();
        end

        $display("covered %0d samples over edge radii, quadrant angles and 11 settings",
                 sample_count);
        $display("including saturation both ways and a long receiver hold-off");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
